FILE: sv/tvbd_pkg.sv
// ----------------------------------------------------------------------------
// tvbd_pkg
// Shared types, constants and round schedule for the block decrypt pipeline.
// ----------------------------------------------------------------------------
package tvbd_pkg;

	localparam logic [31:0] GoldenDelta = 32'h9e37_79b9;
	localparam logic [31:0] SmallDelta  = 32'h0002_8004;
	localparam logic [31:0] StartSum    = 32'h038b_2ada;
	localparam int          SmallRounds = 18;
	localparam int          MidRounds   = 17;
	localparam int          LastRounds  = 17;
	localparam int          NumRounds   = SmallRounds + MidRounds + LastRounds;
	localparam int          SwapRound   = SmallRounds + MidRounds;
	// two half-round cells per round
	localparam int          NumCells    = 2 * NumRounds;
	localparam int          CfgIdxW     = 2;

	typedef enum logic [CfgIdxW-1:0] {
		REG_KEY_WORD0 = 2'd0,
		REG_KEY_WORD1 = 2'd1,
		REG_KEY_WORD2 = 2'd2,
		REG_KEY_WORD3 = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] cipher_low;
		logic [31:0] cipher_high;
	} cipher_t;

	typedef struct packed {
		logic [31:0] plain_low;
		logic [31:0] plain_high;
	} plain_t;

	typedef struct packed {
		logic [31:0] v0;
		logic [31:0] v1;
	} blk_t;

	// control handed from one cell to the next
	typedef struct packed {
		logic en;
		logic vld;
	} cell_ctl_t;

	// running sum seen by round r
	function automatic logic [31:0] round_sum(input int r);
		logic [31:0] s;
		if (r < SmallRounds) begin
			s = StartSum - 32'(r) * SmallDelta;
		end else begin
			s = StartSum - 32'(SmallRounds) * SmallDelta - 32'(r - SmallRounds) * GoldenDelta;
		end
		return s;
	endfunction

	function automatic logic [31:0] mix(input logic [31:0] v, input logic [31:0] ka,
			input logic [31:0] kb, input logic [31:0] s);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		a = {v[27:0], 4'b0000} + ka;
		b = v + s;
		c = {{5{v[31]}}, v[31:5]} + kb;
		return a ^ b ^ c;
	endfunction

endpackage

FILE: sv/tea_variant_block_decrypt.sv
// an accepted request passes through the 104 half-round cells and then the output
// buffer before it shows on plain with plain_valid high
// throughput: one block per cycle unless stalled; the cells hold up to 104 blocks in flight
// cipher_stall rises only when the output skid entry is full, freezing the whole chain
// reset: arst_n clears all valid bits and the four key words to zero
// ----------------------------------------------------------------------------
// tea_variant_block_decrypt
// 52-round TEA-style block decrypt built as a chain of half-round cells.
// ----------------------------------------------------------------------------
module tea_variant_block_decrypt
	import tvbd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cipher_valid,
	output logic               cipher_stall,
	input  cipher_t            cipher,
	output logic               plain_valid,
	input  logic               plain_stall,
	output plain_t             plain,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [31:0]        cfg_data
);

	logic [31:0] key0_q;
	logic [31:0] key1_q;
	logic [31:0] key2_q;
	logic [31:0] key3_q;

	logic              en;
	logic              buf_full;
	logic [NumCells:0] vld;
	blk_t              blk [NumCells+1];
	plain_t            last_plain;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0;
			key1_q <= '0;
			key2_q <= '0;
			key3_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_KEY_WORD0: key0_q <= cfg_data;
				REG_KEY_WORD1: key1_q <= cfg_data;
				REG_KEY_WORD2: key2_q <= cfg_data;
				REG_KEY_WORD3: key3_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en           = !buf_full;
	assign cipher_stall = buf_full;

	assign vld[0]    = cipher_valid;
	assign blk[0].v0 = cipher.cipher_low;
	assign blk[0].v1 = cipher.cipher_high;

	for (genvar k = 0; k < NumCells; k++) begin : g_cell
		// even cells update v1 from v0, odd cells v0 from v1; pairs swap in the last rounds
		localparam int  Round    = k / 2;
		localparam bit  UpdHigh  = (k % 2) == 0;
		localparam bit  UsePair1 = (Round >= SwapRound) ^ !UpdHigh;
		cell_ctl_t ctl;
		assign ctl.en  = en;
		assign ctl.vld = vld[k];
		tvbd_cell #(
			.SUM      (round_sum(Round)),
			.UPD_HIGH (UpdHigh)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.blk    (blk[k]),
			.ka     (UsePair1 ? key2_q : key0_q),
			.kb     (UsePair1 ? key3_q : key1_q),
			.vld_q  (vld[k+1]),
			.blk_q  (blk[k+1])
		);
	end

	assign last_plain.plain_low  = blk[NumCells].v0;
	assign last_plain.plain_high = blk[NumCells].v1;

	tvbd_out_buf u_out_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_valid    (vld[NumCells]),
		.up_data     (last_plain),
		.full        (buf_full),
		.plain_valid (plain_valid),
		.plain       (plain),
		.plain_stall (plain_stall)
	);

	a_chain_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		buf_full |=> $stable(vld[NumCells:1])) else $error("chain moved while stalled");

	a_chain_shifts: assert property (@(posedge clk) disable iff (!arst_n)
		!buf_full |=> vld[NumCells:1] == $past(vld[NumCells-1:0]))
		else $error("chain valid bits did not shift");

	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cipher_stall |-> plain_valid) else $error("stall raised with no request pending");

endmodule

FILE: sv/tvbd_cell.sv
// ----------------------------------------------------------------------------
// tvbd_cell
// One half round: subtracts the mix of one word from the other, registered.
// ----------------------------------------------------------------------------
module tvbd_cell
	import tvbd_pkg::*;
#(
	parameter logic [31:0] SUM      = StartSum,
	parameter bit          UPD_HIGH = 1'b1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cell_ctl_t   ctl,
	input  blk_t        blk,
	input  logic [31:0] ka,
	input  logic [31:0] kb,
	output logic        vld_q,
	output blk_t        blk_q
);

	blk_t nxt;

	always_comb begin
		nxt = blk;
		if (UPD_HIGH) begin
			nxt.v1 = blk.v1 - mix(blk.v0, ka, kb, SUM);
		end else begin
			nxt.v0 = blk.v0 - mix(blk.v1, ka, kb, SUM);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.en) begin
			vld_q <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			blk_q <= nxt;
		end
	end

endmodule

FILE: sv/tvbd_out_buf.sv
// ----------------------------------------------------------------------------
// tvbd_out_buf
// Output register with a skid entry that holds a block arriving during a stall.
// ----------------------------------------------------------------------------
module tvbd_out_buf
	import tvbd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   up_valid,
	input  plain_t up_data,
	output logic   full,
	output logic   plain_valid,
	output plain_t plain,
	input  logic   plain_stall
);

	logic   ov_q;
	logic   sv_q;
	plain_t od_q;
	plain_t sd_q;

	logic load_out;
	logic load_skid;
	logic drain_skid;

	assign drain_skid = sv_q && !plain_stall;
	assign load_out   = !sv_q && up_valid && (!ov_q || !plain_stall);
	assign load_skid  = !sv_q && up_valid && ov_q && plain_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else begin
			if (drain_skid) begin
				sv_q <= 1'b0;
			end else if (load_skid) begin
				sv_q <= 1'b1;
			end
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (!sv_q && !plain_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drain_skid) begin
			od_q <= sd_q;
		end else if (load_out) begin
			od_q <= up_data;
		end
		if (load_skid) begin
			sd_q <= up_data;
		end
	end

	assign full        = sv_q;
	assign plain_valid = ov_q;
	assign plain       = od_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q |-> ov_q) else $error("skid entry held without output entry");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sv_q) |-> $past(plain_stall) && $past(ov_q))
		else $error("skid filled while output was free");

	a_drain_keeps_out: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q && !plain_stall |=> ov_q && !sv_q)
		else $error("skid drain lost a request");

endmodule
